/* rtl/core/msl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed and load monitor package
// Shared widths, reset values, mode and event codes and register indexes.
// ----------------------------------------------------------------------------
package msl_pkg;

    localparam int SPEED_BITS_DEFAULT  = 16;
    localparam int SAMPLE_BITS_DEFAULT = 12;

    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_SAMPLE_BITS = 12;
    localparam int COUNT_BITS      = 16;
    localparam int MODE_BITS       = 2;
    localparam int EVENT_BITS      = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_LOW     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_HIGH    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOST_LOW       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOST_HIGH      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CURRENT_CENTER = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_NEEDED  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOST_NEEDED    = 3'd6;

    localparam logic [CFG_DATA_BITS-1:0] RST_STABLE_LOW     = 16'd502;
    localparam logic [CFG_DATA_BITS-1:0] RST_STABLE_HIGH    = 16'd522;
    localparam logic [CFG_DATA_BITS-1:0] RST_LOST_LOW       = 16'd358;
    localparam logic [CFG_DATA_BITS-1:0] RST_LOST_HIGH      = 16'd666;
    localparam logic [CFG_DATA_BITS-1:0] RST_CURRENT_CENTER = 16'd2048;
    localparam logic [COUNT_BITS-1:0]    RST_STABLE_NEEDED  = 16'd400;
    localparam logic [COUNT_BITS-1:0]    RST_LOST_NEEDED    = 16'd10;

    localparam logic [MODE_BITS-1:0] MODE_INIT      = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_STEADY    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LOST      = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_RECOVERED = 2'd3;

    localparam logic [EVENT_BITS-1:0] EV_NONE      = 2'd0;
    localparam logic [EVENT_BITS-1:0] EV_RECOVERED = 2'd1;
    localparam logic [EVENT_BITS-1:0] EV_OVER      = 2'd2;
    localparam logic [EVENT_BITS-1:0] EV_UNDER     = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT      = 4'b0001,
        ST_STEADY    = 4'b0010,
        ST_LOST      = 4'b0100,
        ST_RECOVERED = 4'b1000
    } mon_state_t;

endpackage

/* rtl/core/motor_speed_load_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed and load monitor
// Tracks speed stability and loss over runs of samples and judges motor
// current against a captured baseline after the speed recovers.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the s_ channel carries a speed sample (unsigned Q8.8), a
// current sample and a direction bit. Every item gives exactly one result
// item on the m_ channel with the mode after the item, an event code and the
// run counter. The cfg channel writes the seven threshold registers by index;
// it is always ready. Writes are to be made only while no item is in flight;
// the block itself does not enforce this. An item is held in an input
// register; its mode and counter update is done from there into the result
// register, which drives m_valid. One item is accepted every cycle while the
// receiver takes results; the rate is set by the single mode and counter
// update between the two registers.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready drops only when both are full.
// Reset clears the mode to init, the run counter and baseline to zero,
// empties both registers and loads the default thresholds.
// ----------------------------------------------------------------------------
module motor_speed_load_monitor #(
    parameter int SPEED_BITS  = msl_pkg::SPEED_BITS_DEFAULT,
    parameter int SAMPLE_BITS = msl_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [msl_pkg::CFG_DATA_BITS-1:0] cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [SPEED_BITS-1:0]             s_speed,
    input  logic [SAMPLE_BITS-1:0]            s_current_sample,
    input  logic                              s_direction_up,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [msl_pkg::MODE_BITS-1:0]     m_mode,
    output logic [msl_pkg::EVENT_BITS-1:0]    m_event_res,
    output logic [msl_pkg::COUNT_BITS-1:0]    m_run_count
);

    localparam int CB = msl_pkg::COUNT_BITS;
    localparam int SPD_USE = (SPEED_BITS < msl_pkg::CFG_DATA_BITS) ?
                             SPEED_BITS : msl_pkg::CFG_DATA_BITS;
    localparam int SMP_USE = (SAMPLE_BITS < msl_pkg::CFG_SAMPLE_BITS) ?
                             SAMPLE_BITS : msl_pkg::CFG_SAMPLE_BITS;
    localparam int LOAD_BITS = SAMPLE_BITS + 2;

    logic [SPEED_BITS-1:0]  stable_low_reg, stable_high_reg;
    logic [SPEED_BITS-1:0]  lost_low_reg, lost_high_reg;
    logic [SAMPLE_BITS-1:0] center_reg;
    logic [CB-1:0]          stable_needed_reg, lost_needed_reg;

    logic                   in_valid_reg;
    logic [SPEED_BITS-1:0]  in_speed_reg;
    logic [SAMPLE_BITS-1:0] in_cur_reg;
    logic                   in_up_reg;

    msl_pkg::mon_state_t    state_reg, state_next;
    logic [CB-1:0]          count_reg, count_next;
    logic [SAMPLE_BITS-1:0] baseline_reg, baseline_next;

    logic                   res_valid_reg;
    logic [msl_pkg::MODE_BITS-1:0]  res_mode_reg, res_mode_next;
    logic [msl_pkg::EVENT_BITS-1:0] res_event_reg, res_event_next;

    logic                   advance;
    logic                   step;
    logic [SPEED_BITS-1:0]  spd_in;
    logic [SAMPLE_BITS-1:0] cur_in;
    logic                   in_stable, out_lost;
    logic                   hit;
    logic [CB-1:0]          needed, thr, count_inc;
    logic                   reached;
    logic [SAMPLE_BITS-1:0] dev_cur, dev_base;
    logic [LOAD_BITS-1:0]   dev_cur2, dev_base3, dev_base1;

    assign cfg_ready = 1'b1;
    assign advance   = !res_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;

    assign spd_in = SPEED_BITS'(s_speed[SPD_USE-1:0]);
    assign cur_in = SAMPLE_BITS'(s_current_sample[SMP_USE-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_low_reg    <= SPEED_BITS'(msl_pkg::RST_STABLE_LOW);
            stable_high_reg   <= SPEED_BITS'(msl_pkg::RST_STABLE_HIGH);
            lost_low_reg      <= SPEED_BITS'(msl_pkg::RST_LOST_LOW);
            lost_high_reg     <= SPEED_BITS'(msl_pkg::RST_LOST_HIGH);
            center_reg        <= SAMPLE_BITS'(msl_pkg::RST_CURRENT_CENTER);
            stable_needed_reg <= msl_pkg::RST_STABLE_NEEDED;
            lost_needed_reg   <= msl_pkg::RST_LOST_NEEDED;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msl_pkg::REG_STABLE_LOW:    stable_low_reg  <= SPEED_BITS'(cfg_data);
                msl_pkg::REG_STABLE_HIGH:   stable_high_reg <= SPEED_BITS'(cfg_data);
                msl_pkg::REG_LOST_LOW:      lost_low_reg    <= SPEED_BITS'(cfg_data);
                msl_pkg::REG_LOST_HIGH:     lost_high_reg   <= SPEED_BITS'(cfg_data);
                msl_pkg::REG_CURRENT_CENTER: begin
                    center_reg <= SAMPLE_BITS'(cfg_data[SMP_USE-1:0]);
                end
                msl_pkg::REG_STABLE_NEEDED: stable_needed_reg <= cfg_data;
                msl_pkg::REG_LOST_NEEDED:   lost_needed_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_speed_reg <= spd_in;
            in_cur_reg   <= cur_in;
            in_up_reg    <= s_direction_up;
        end
    end

    assign in_stable = (in_speed_reg >= stable_low_reg) && (in_speed_reg <= stable_high_reg);
    assign out_lost  = (in_speed_reg < lost_low_reg) || (in_speed_reg > lost_high_reg);

    assign hit    = (state_reg == msl_pkg::ST_STEADY) ? out_lost : in_stable;
    assign needed = (state_reg == msl_pkg::ST_STEADY) ? lost_needed_reg : stable_needed_reg;
    assign thr    = (needed == '0) ? CB'(1) : needed;

    always_comb begin
        if (!hit) begin
            count_inc = '0;
        end else if (count_reg == {CB{1'b1}}) begin
            count_inc = count_reg;
        end else begin
            count_inc = count_reg + CB'(1);
        end
    end

    assign reached = (count_inc >= thr);

    assign dev_cur   = (in_cur_reg >= center_reg) ? (in_cur_reg - center_reg) :
                                                    (center_reg - in_cur_reg);
    assign dev_base  = (baseline_reg >= center_reg) ? (baseline_reg - center_reg) :
                                                      (center_reg - baseline_reg);
    assign dev_cur2  = {1'b0, dev_cur, 1'b0};
    assign dev_base1 = LOAD_BITS'(dev_base);
    assign dev_base3 = {1'b0, dev_base, 1'b0} + dev_base1;

    always_comb begin
        state_next     = state_reg;
        baseline_next  = baseline_reg;
        count_next     = reached ? '0 : count_inc;
        res_event_next = msl_pkg::EV_NONE;
        unique case (state_reg)
            msl_pkg::ST_INIT: begin
                if (reached) begin
                    state_next    = msl_pkg::ST_STEADY;
                    baseline_next = in_cur_reg;
                end
            end
            msl_pkg::ST_STEADY: begin
                if (reached) begin
                    state_next = msl_pkg::ST_LOST;
                end
            end
            msl_pkg::ST_LOST: begin
                if (reached) begin
                    state_next     = msl_pkg::ST_RECOVERED;
                    res_event_next = msl_pkg::EV_RECOVERED;
                end
            end
            msl_pkg::ST_RECOVERED: begin
                count_next = count_reg;
                state_next = msl_pkg::ST_STEADY;
                if (in_up_reg && (dev_cur2 > dev_base3)) begin
                    res_event_next = msl_pkg::EV_OVER;
                end else if (!in_up_reg && (dev_cur2 < dev_base1)) begin
                    res_event_next = msl_pkg::EV_UNDER;
                end
            end
            default: begin
                state_next = msl_pkg::ST_INIT;
            end
        endcase
    end

    always_comb begin
        unique case (state_next)
            msl_pkg::ST_INIT:      res_mode_next = msl_pkg::MODE_INIT;
            msl_pkg::ST_STEADY:    res_mode_next = msl_pkg::MODE_STEADY;
            msl_pkg::ST_LOST:      res_mode_next = msl_pkg::MODE_LOST;
            msl_pkg::ST_RECOVERED: res_mode_next = msl_pkg::MODE_RECOVERED;
            default:               res_mode_next = msl_pkg::MODE_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= msl_pkg::ST_INIT;
            count_reg     <= '0;
            baseline_reg  <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                state_reg    <= state_next;
                count_reg    <= count_next;
                baseline_reg <= baseline_next;
            end
            if (advance) begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_mode_reg  <= res_mode_next;
            res_event_reg <= res_event_next;
        end
    end

    assign m_valid     = res_valid_reg;
    assign m_mode      = res_mode_reg;
    assign m_event_res = res_event_reg;
    assign m_run_count = count_reg;

endmodule

/* tb/sv/msl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed and load monitor checker
// Follows the threshold register writes and every accepted speed sample. It
// keeps its own copy of the monitor's mode, run counter and baseline current,
// predicts the status item that each sample produces, and compares the status
// items that leave the block field by field, in order.
// ----------------------------------------------------------------------------
module msl_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [msl_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [msl_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic [msl_pkg::SPEED_BITS_DEFAULT-1:0]  s_speed,
    input  logic [msl_pkg::SAMPLE_BITS_DEFAULT-1:0] s_current_sample,
    input  logic                                    s_direction_up,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [msl_pkg::MODE_BITS-1:0]           m_mode,
    input  logic [msl_pkg::EVENT_BITS-1:0]          m_event_res,
    input  logic [msl_pkg::COUNT_BITS-1:0]          m_run_count,
    output int                                      mismatches,
    output int                                      outstanding,
    output int                                      statuses_checked,
    output int                                      recoveries_seen,
    output int                                      load_events_seen
);
    import msl_pkg::*;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [EVENT_BITS-1:0] ev;
        logic [COUNT_BITS-1:0] run_cnt;
    } status_t;

    status_t predicted_status_q[$];

    logic [15:0]          win_stable_lo;
    logic [15:0]          win_stable_hi;
    logic [15:0]          win_lost_lo;
    logic [15:0]          win_lost_hi;
    logic [11:0]          zero_current;
    logic [15:0]          stable_run_len;
    logic [15:0]          lost_run_len;
    logic [MODE_BITS-1:0] mon_mode;
    logic [15:0]          run_cnt;
    logic [11:0]          baseline;
    int                   fail_total;
    int                   checked_total;
    int                   recovered_total;
    int                   load_total;

    function automatic bit run_complete(input bit hit, input logic [15:0] needed);
        logic [15:0] goal;
        goal = (needed == 16'd0) ? 16'd1 : needed;
        if (!hit) begin
            run_cnt = 16'd0;
        end else if (run_cnt != 16'hFFFF) begin
            run_cnt = run_cnt + 16'd1;
        end
        if (run_cnt >= goal) begin
            run_cnt = 16'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic status_t predict_status(input logic [15:0] speed,
                                               input logic [11:0] cur,
                                               input logic up);
        bit      in_stable;
        bit      out_lost;
        int      dev_now;
        int      dev_base;
        status_t r;
        in_stable = (speed >= win_stable_lo) && (speed <= win_stable_hi);
        out_lost  = (speed < win_lost_lo) || (speed > win_lost_hi);
        r.ev = EV_NONE;
        case (mon_mode)
            MODE_INIT: begin
                if (run_complete(in_stable, stable_run_len)) begin
                    mon_mode = MODE_STEADY;
                    baseline = cur;
                end
            end
            MODE_STEADY: begin
                if (run_complete(out_lost, lost_run_len)) begin
                    mon_mode = MODE_LOST;
                end
            end
            MODE_LOST: begin
                if (run_complete(in_stable, stable_run_len)) begin
                    mon_mode = MODE_RECOVERED;
                    r.ev = EV_RECOVERED;
                end
            end
            default: begin
                dev_now  = (cur >= zero_current) ? int'(cur - zero_current)
                                                 : int'(zero_current - cur);
                dev_base = (baseline >= zero_current) ? int'(baseline - zero_current)
                                                      : int'(zero_current - baseline);
                if (up && (2 * dev_now > 3 * dev_base)) begin
                    r.ev = EV_OVER;
                end else if (!up && (2 * dev_now < dev_base)) begin
                    r.ev = EV_UNDER;
                end
                mon_mode = MODE_STEADY;
            end
        endcase
        r.mode    = mon_mode;
        r.run_cnt = run_cnt;
        return r;
    endfunction

    always @(posedge aclk) begin
        status_t want;
        if (!aresetn) begin
            win_stable_lo   = RST_STABLE_LOW;
            win_stable_hi   = RST_STABLE_HIGH;
            win_lost_lo     = RST_LOST_LOW;
            win_lost_hi     = RST_LOST_HIGH;
            zero_current    = RST_CURRENT_CENTER[11:0];
            stable_run_len  = RST_STABLE_NEEDED;
            lost_run_len    = RST_LOST_NEEDED;
            mon_mode        = MODE_INIT;
            run_cnt         = 16'd0;
            baseline        = 12'd0;
            fail_total      = 0;
            checked_total   = 0;
            recovered_total = 0;
            load_total      = 0;
            predicted_status_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_status_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: status item with none expected: mode %0d event %0d count %0d",
                                 $time, m_mode, m_event_res, m_run_count);
                    end
                end else begin
                    want = predicted_status_q.pop_front();
                    checked_total++;
                    if (want.ev == EV_RECOVERED) begin
                        recovered_total++;
                    end else if (want.ev != EV_NONE) begin
                        load_total++;
                    end
                    if (m_mode !== want.mode || m_event_res !== want.ev
                            || m_run_count !== want.run_cnt) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: status mismatch, expected mode %0d event %0d count %0d",
                                     $time, want.mode, want.ev, want.run_cnt);
                            $display("%0t:                  got      mode %0d event %0d count %0d",
                                     $time, m_mode, m_event_res, m_run_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                predicted_status_q.push_back(
                    predict_status(s_speed, s_current_sample, s_direction_up));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_STABLE_LOW:     win_stable_lo  = cfg_data;
                    REG_STABLE_HIGH:    win_stable_hi  = cfg_data;
                    REG_LOST_LOW:       win_lost_lo    = cfg_data;
                    REG_LOST_HIGH:      win_lost_hi    = cfg_data;
                    REG_CURRENT_CENTER: zero_current   = cfg_data[11:0];
                    REG_STABLE_NEEDED:  stable_run_len = cfg_data;
                    REG_LOST_NEEDED:    lost_run_len   = cfg_data;
                    default: ;
                endcase
            end
        end
        mismatches       <= fail_total;
        outstanding      <= predicted_status_q.size();
        statuses_checked <= checked_total;
        recoveries_seen  <= recovered_total;
        load_events_seen <= load_total;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed and load monitor testbench
// Drives threshold settings and speed sample streams into the monitor, with
// a directed walk through every mode and event followed by random runs of
// in-window and out-of-window speeds under varied sender and receiver idling.
// A separate checker predicts and compares every status item.
// ----------------------------------------------------------------------------
module testbench;
    import msl_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                            aclk             = 1'b0;
    logic                            aresetn          = 1'b0;
    logic                            cfg_valid        = 1'b0;
    logic [CFG_INDEX_BITS-1:0]       cfg_index        = REG_STABLE_LOW;
    logic [CFG_DATA_BITS-1:0]        cfg_data         = '0;
    logic                            s_valid          = 1'b0;
    logic [SPEED_BITS_DEFAULT-1:0]   s_speed          = '0;
    logic [SAMPLE_BITS_DEFAULT-1:0]  s_current_sample = '0;
    logic                            s_direction_up   = 1'b0;
    logic                            m_ready          = 1'b0;
    logic                            cfg_ready;
    logic                            s_ready;
    logic                            m_valid;
    logic [MODE_BITS-1:0]            m_mode;
    logic [EVENT_BITS-1:0]           m_event_res;
    logic [COUNT_BITS-1:0]           m_run_count;

    int mismatches;
    int outstanding;
    int statuses_checked;
    int recoveries_seen;
    int load_events_seen;

    int          gap_pct       = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          idle_cycles   = 0;
    int          samples_sent  = 0;
    logic [15:0] cfg_copy [7];

    always #5 aclk = ~aclk;

    motor_speed_load_monitor dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_speed          (s_speed),
        .s_current_sample (s_current_sample),
        .s_direction_up   (s_direction_up),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mode           (m_mode),
        .m_event_res      (m_event_res),
        .m_run_count      (m_run_count)
    );

    msl_checker msl_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_speed          (s_speed),
        .s_current_sample (s_current_sample),
        .s_direction_up   (s_direction_up),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mode           (m_mode),
        .m_event_res      (m_event_res),
        .m_run_count      (m_run_count),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .statuses_checked (statuses_checked),
        .recoveries_seen  (recoveries_seen),
        .load_events_seen (load_events_seen)
    );

    // A hold-off request stalls the receiver for a long stretch.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        cfg_valid     <= 1'b1;
        cfg_index     <= idx;
        cfg_data      <= val;
        cfg_copy[idx] = val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_setting(input logic [15:0] sl, input logic [15:0] sh,
                                input logic [15:0] ll, input logic [15:0] lh,
                                input logic [11:0] ctr, input logic [15:0] sn,
                                input logic [15:0] ln);
        logic [3:0] spare;
        spare = 4'($urandom);
        cfg_write(REG_STABLE_LOW, sl);
        cfg_write(REG_STABLE_HIGH, sh);
        cfg_write(REG_LOST_LOW, ll);
        cfg_write(REG_LOST_HIGH, lh);
        cfg_write(REG_CURRENT_CENTER, {spare, ctr});
        cfg_write(REG_STABLE_NEEDED, sn);
        cfg_write(REG_LOST_NEEDED, ln);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] speed, input logic [11:0] cur,
                               input logic up);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_speed          <= speed;
        s_current_sample <= cur;
        s_direction_up   <= up;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_stable_speed();
        return 16'($urandom_range(cfg_copy[REG_STABLE_HIGH], cfg_copy[REG_STABLE_LOW]));
    endfunction

    function automatic logic [15:0] pick_lost_speed();
        logic [15:0] lo;
        logic [15:0] hi;
        lo = cfg_copy[REG_LOST_LOW];
        hi = cfg_copy[REG_LOST_HIGH];
        if (lo != 16'd0 && (hi == 16'hFFFF || $urandom_range(1) == 1)) begin
            return 16'($urandom_range(lo - 16'd1, 0));
        end
        if (hi != 16'hFFFF) begin
            return 16'($urandom_range(16'hFFFF, hi + 16'd1));
        end
        return 16'($urandom);
    endfunction

    // Small offsets around zero current make the undercurrent case likely.
    function automatic logic [11:0] pick_current();
        logic [11:0] ctr;
        ctr = cfg_copy[REG_CURRENT_CENTER][11:0];
        case ($urandom_range(4))
            0: return 12'($urandom);
            1: return ctr + 12'($urandom_range(15)) - 12'd8;
            2: return 12'd0;
            3: return 12'hFFF;
            default: return ctr + 12'($urandom_range(600)) - 12'd300;
        endcase
    endfunction

    // Runs are mostly long enough to switch the mode (exactly or one longer), sometimes one short.
    function automatic int run_for(input logic [15:0] needed);
        int len;
        len = (needed == 16'd0) ? 1 : int'(needed);
        if ($urandom_range(3) == 0) begin
            return len - 1;
        end
        return len + $urandom_range(1);
    endfunction

    task automatic random_phase(input int n_samples);
        int          sent;
        int          kind;
        int          run_len;
        int          i;
        logic [15:0] speed;
        sent = 0;
        while (sent < n_samples) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                run_len = run_for(cfg_copy[REG_STABLE_NEEDED]);
            end else if (kind < 7) begin
                run_len = run_for(cfg_copy[REG_LOST_NEEDED]);
            end else begin
                run_len = $urandom_range(3, 1);
            end
            for (i = 0; i < run_len; i++) begin
                if (kind < 4) begin
                    speed = pick_stable_speed();
                end else if (kind < 7) begin
                    speed = pick_lost_speed();
                end else begin
                    speed = 16'($urandom);
                end
                send_sample(speed, pick_current(), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk through init, steady, lost and recovered, with all three events.
        load_setting(16'd100, 16'd200, 16'd50, 16'd300, 12'd2048, 16'd3, 16'd2);
        send_sample(16'd150, 12'd0, 1'b0);
        send_sample(16'd100, 12'd0, 1'b1);
        send_sample(16'd99, 12'd100, 1'b0);
        send_sample(16'd200, 12'd2048, 1'b1);
        send_sample(16'd150, 12'd3000, 1'b0);
        send_sample(16'd101, 12'd2548, 1'b1);
        send_sample(16'd50, 12'd2548, 1'b0);
        send_sample(16'd0, 12'd2548, 1'b1);
        send_sample(16'hFFFF, 12'd2548, 1'b0);
        send_sample(16'd150, 12'd1000, 1'b1);
        send_sample(16'd150, 12'd1000, 1'b1);
        send_sample(16'd150, 12'd1000, 1'b1);
        send_sample(16'd0, 12'hFFF, 1'b1);
        send_sample(16'd301, 12'd2048, 1'b0);
        send_sample(16'd49, 12'd2048, 1'b0);
        send_sample(16'd150, 12'd2048, 1'b0);
        send_sample(16'd150, 12'd2048, 1'b0);
        send_sample(16'd150, 12'd2048, 1'b0);
        send_sample(16'd512, 12'd2048, 1'b0);
        wait_drained;

        // Zero run lengths act as one; the lost window is inverted.
        load_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 12'hFFF, 16'd0, 16'd0);
        send_sample(16'd1000, 12'd2000, 1'b1);
        send_sample(16'd0, 12'd2000, 1'b0);
        send_sample(16'hFFFF, 12'd0, 1'b1);
        send_sample(16'd32768, 12'd4000, 1'b0);
        wait_drained;

        // Empty stable window and the longest run lengths.
        load_setting(16'd600, 16'd500, 16'd0, 16'hFFFF, 12'd0, 16'hFFFF, 16'hFFFF);
        send_sample(16'd550, 12'd1234, 1'b1);
        send_sample(16'hFFFF, 12'd2345, 1'b0);
        wait_drained;

        load_setting(16'd1000, 16'd1100, 16'd800, 16'd1300, 12'd2048, 16'd2, 16'd2);
        random_phase(110);
        wait_drained;

        gap_pct   = 80;
        stall_pct = 0;
        load_setting(16'd0, 16'd400, 16'd0, 16'hFFFE, 12'd0, 16'd1, 16'd1);
        random_phase(110);
        wait_drained;

        gap_pct   = 0;
        stall_pct = 80;
        load_setting(16'd65000, 16'hFFFF, 16'd60000, 16'hFFFF, 12'hFFF, 16'd4, 16'd3);
        random_phase(110);
        wait_drained;

        gap_pct   = 10;
        stall_pct = 10;
        load_setting(16'd300, 16'd700, 16'd200, 16'd900, 12'($urandom), 16'd3, 16'd5);
        random_phase(110);
        wait_drained;

        // The receiver holds off while samples keep coming, so the block backs up.
        gap_pct   = 0;
        stall_pct = 0;
        load_setting(16'd1000, 16'd1100, 16'd800, 16'd1300, 12'd2048, 16'd2, 16'd1);
        hold_requests++;
        random_phase(40);
        wait_drained;

        repeat (20) @(posedge aclk);
        $display("Sent %0d speed samples over eight threshold settings, with sender gaps,",
                 samples_sent);
        $display("receiver stalls and a long hold-off; %0d status items checked, %0d %s %0d %s",
                 statuses_checked, recoveries_seen, "recoveries,", load_events_seen,
                 "load events.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
